// ===== design/s20sc_pkg.sv =====
// ----------------------------------------------------------------------------
// s20sc_pkg
// shared types, constants and round functions of the salsa20 stream cipher
// ----------------------------------------------------------------------------
package s20sc_pkg;

    localparam int unsigned ROUND_COUNT_DEF = 20;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned CFG_IDX_W       = 3;
    localparam int unsigned CFG_DATA_W      = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE      = 3'd4;

    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    typedef logic [31:0]          word_t;
    typedef word_t [15:0]         matrix_t;
    typedef logic [63:0]          ctr_t;
    typedef logic [5:0]           pos_t;
    typedef logic [3:0][63:0]     key_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        pos_t       pos;
        logic       new_block;
        ctr_t       ctr;
    } q_entry_t;

    typedef struct packed {
        logic busy;
        logic done;
        ctr_t ctr;
    } core_stat_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_ADD,
        CORE_DONE
    } core_state_t;

    // quarter steps of one column round: target, two sources, rotation
    localparam logic [3:0] STEP_DST [4][4] = '{
        '{4'd4,  4'd9,  4'd14, 4'd3},
        '{4'd8,  4'd13, 4'd2,  4'd7},
        '{4'd12, 4'd1,  4'd6,  4'd11},
        '{4'd0,  4'd5,  4'd10, 4'd15}
    };
    localparam logic [3:0] STEP_SRC_A [4][4] = '{
        '{4'd0,  4'd5,  4'd10, 4'd15},
        '{4'd0,  4'd5,  4'd10, 4'd15},
        '{4'd8,  4'd13, 4'd2,  4'd7},
        '{4'd12, 4'd1,  4'd6,  4'd11}
    };
    localparam logic [3:0] STEP_SRC_B [4][4] = '{
        '{4'd12, 4'd1,  4'd6,  4'd11},
        '{4'd4,  4'd9,  4'd14, 4'd3},
        '{4'd4,  4'd9,  4'd14, 4'd3},
        '{4'd8,  4'd13, 4'd2,  4'd7}
    };
    localparam int unsigned STEP_ROT [4] = '{7, 9, 13, 18};

    function automatic word_t rotl(word_t v, int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic matrix_t col_step(matrix_t m, int unsigned s);
        matrix_t r;
        r = m;
        for (int i = 0; i < 4; i++) begin
            r[STEP_DST[s][i]] = m[STEP_DST[s][i]]
                ^ rotl(m[STEP_SRC_A[s][i]] + m[STEP_SRC_B[s][i]], STEP_ROT[s]);
        end
        return r;
    endfunction

    function automatic matrix_t transpose(matrix_t m);
        matrix_t t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[c*4 + r] = m[r*4 + c];
            end
        end
        return t;
    endfunction

    // first half: steps with rotation 7 and 9; second half: 13, 18 and transpose
    function automatic matrix_t half_round(matrix_t m, logic second);
        matrix_t r;
        if (!second) begin
            r = col_step(col_step(m, 0), 1);
        end else begin
            r = transpose(col_step(col_step(m, 2), 3));
        end
        return r;
    endfunction

    function automatic matrix_t init_matrix(key_t key, ctr_t nonce_v, ctr_t ctr);
        matrix_t m;
        m[0]  = SIGMA_0;
        m[1]  = key[0][31:0];
        m[2]  = key[0][63:32];
        m[3]  = key[1][31:0];
        m[4]  = key[1][63:32];
        m[5]  = SIGMA_1;
        m[6]  = nonce_v[63:32];
        m[7]  = nonce_v[31:0];
        m[8]  = ctr[31:0];
        m[9]  = ctr[63:32];
        m[10] = SIGMA_2;
        m[11] = key[2][31:0];
        m[12] = key[2][63:32];
        m[13] = key[3][31:0];
        m[14] = key[3][63:32];
        m[15] = SIGMA_3;
        return m;
    endfunction

    function automatic matrix_t add_matrix(matrix_t a, matrix_t b);
        matrix_t r;
        for (int i = 0; i < 16; i++) begin
            r[i] = a[i] + b[i];
        end
        return r;
    endfunction

endpackage

// ===== design/s20sc_front.sv =====
// ----------------------------------------------------------------------------
// s20sc_front
// accepts message bytes, tracks byte position and block counter, tags block starts
// ----------------------------------------------------------------------------
module s20sc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_in_byte,
    input  logic                  s_last_byte,
    output logic                  push,
    output s20sc_pkg::q_entry_t   push_entry,
    input  logic                  q_full
);
    import s20sc_pkg::*;

    pos_t pos_reg, pos_next;
    ctr_t ctr_reg, ctr_next;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    always_comb begin
        push_entry.data      = s_in_byte;
        push_entry.last      = s_last_byte;
        push_entry.pos       = pos_reg;
        push_entry.new_block = (pos_reg == '0);
        push_entry.ctr       = ctr_reg;
    end

    always_comb begin
        pos_next = pos_reg;
        ctr_next = ctr_reg;
        if (push) begin
            if (s_last_byte) begin
                pos_next = '0;
                ctr_next = '0;
            end else begin
                pos_next = pos_reg + 6'd1;
                if (pos_reg == 6'd63) begin
                    ctr_next = ctr_reg + 64'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            ctr_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            ctr_reg <= ctr_next;
        end
    end

endmodule

// ===== design/s20sc_queue.sv =====
// ----------------------------------------------------------------------------
// s20sc_queue
// short queue of tagged bytes between front and back
// ----------------------------------------------------------------------------
module s20sc_queue #(
    parameter int unsigned DEPTH = s20sc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  s20sc_pkg::q_entry_t   push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output s20sc_pkg::q_entry_t   head
);
    import s20sc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    q_entry_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full       = (cnt_reg == CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== design/s20sc_core.sv =====
// ----------------------------------------------------------------------------
// s20sc_core
// key and nonce registers and the salsa20 block function, half a round per cycle
// ----------------------------------------------------------------------------
module s20sc_core #(
    parameter int unsigned ROUND_COUNT = s20sc_pkg::ROUND_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [s20sc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [s20sc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              start,
    input  s20sc_pkg::ctr_t                   start_ctr,
    output s20sc_pkg::core_stat_t             stat,
    output s20sc_pkg::matrix_t                words
);
    import s20sc_pkg::*;

    localparam int unsigned HALF_W = $clog2(2 * ROUND_COUNT);
    localparam logic [HALF_W-1:0] HALF_LAST = HALF_W'(2 * ROUND_COUNT - 1);

    key_t                key_reg;
    ctr_t                nonce_reg;
    core_state_t         state_reg, state_next;
    matrix_t             mat_reg, mat_next;
    ctr_t                ctr_reg, ctr_next;
    logic [HALF_W-1:0]   half_reg, half_next;
    logic                cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;
    assign words     = mat_reg;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            nonce_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_index)
                CFG_KEY_PAIR_0: key_reg[0] <= cfg_data;
                CFG_KEY_PAIR_1: key_reg[1] <= cfg_data;
                CFG_KEY_PAIR_2: key_reg[2] <= cfg_data;
                CFG_KEY_PAIR_3: key_reg[3] <= cfg_data;
                CFG_NONCE:      nonce_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state; a config write drops any block in flight or held
    always_comb begin
        state_next = state_reg;
        if (cfg_wr) begin
            state_next = CORE_IDLE;
        end else if (start) begin
            state_next = CORE_ROUND;
        end else begin
            case (state_reg)
                CORE_ROUND: begin
                    if (half_reg == HALF_LAST) begin
                        state_next = CORE_ADD;
                    end
                end
                CORE_ADD:  state_next = CORE_DONE;
                default:   state_next = state_reg;
            endcase
        end
    end

    // status outputs
    always_comb begin
        stat.busy = (state_reg == CORE_ROUND) || (state_reg == CORE_ADD);
        stat.done = (state_reg == CORE_DONE);
        stat.ctr  = ctr_reg;
    end

    // datapath
    always_comb begin
        mat_next  = mat_reg;
        ctr_next  = ctr_reg;
        half_next = half_reg;
        if (start) begin
            mat_next  = init_matrix(key_reg, nonce_reg, start_ctr);
            ctr_next  = start_ctr;
            half_next = '0;
        end else begin
            case (state_reg)
                CORE_ROUND: begin
                    mat_next  = half_round(mat_reg, half_reg[0]);
                    half_next = half_reg + HALF_W'(1);
                end
                CORE_ADD: begin
                    mat_next = add_matrix(mat_reg, init_matrix(key_reg, nonce_reg, ctr_reg));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CORE_IDLE;
            half_reg  <= '0;
        end else begin
            state_reg <= state_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge aclk) begin
        mat_reg <= mat_next;
        ctr_reg <= ctr_next;
    end

endmodule

// ===== design/s20sc_back.sv =====
// ----------------------------------------------------------------------------
// s20sc_back
// keystream buffer, block requests to the core, xor and output register
// ----------------------------------------------------------------------------
module s20sc_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    head_valid,
    input  s20sc_pkg::q_entry_t     head,
    output logic                    pop,
    input  s20sc_pkg::core_stat_t   core_stat,
    input  s20sc_pkg::matrix_t      core_words,
    output logic                    core_start,
    output s20sc_pkg::ctr_t         core_start_ctr,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_out_byte,
    output logic                    m_out_last
);
    import s20sc_pkg::*;

    matrix_t    ks_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       hit, pending, out_free;
    matrix_t    src;
    word_t      ks_word;
    logic [7:0] ks_byte;

    assign hit      = head.new_block && core_stat.done && (core_stat.ctr == head.ctr);
    assign pending  = core_stat.busy && (core_stat.ctr == head.ctr);
    assign out_free = !out_valid_reg || m_ready;
    assign pop      = head_valid && out_free && (!head.new_block || hit);

    // on a block start, prefetch the following block; otherwise request the missing one
    assign core_start = (pop && head.new_block)
                     || (head_valid && head.new_block && !hit && !pending);
    assign core_start_ctr = hit ? head.ctr + 64'd1 : head.ctr;

    assign src     = head.new_block ? core_words : ks_reg;
    assign ks_word = src[head.pos[5:2]];
    assign ks_byte = ks_word[{head.pos[1:0], 3'b000} +: 8];

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_byte_reg <= head.data ^ ks_byte;
            out_last_reg <= head.last;
            if (head.new_block) begin
                ks_reg <= core_words;
            end
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_out_last = out_last_reg;

endmodule

// ===== design/salsa20_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// salsa20_stream_cipher
// salsa20 stream cipher, one message byte in and one byte out per beat
// ----------------------------------------------------------------------------
//  channel   ports                                  beat
//  input     s_valid s_ready s_in_byte s_last_byte   one message byte
//  output    m_valid m_ready m_out_byte m_out_last   one xored byte
//  config    cfg_valid cfg_ready cfg_index cfg_data  one 64-bit register
//
//  one byte per cycle inside a keystream block while bytes are queued and the
//  output is not stalled; the block function runs half a round per cycle, and
//  the next block is prefetched while the current one is in use.
//  the first byte of each message waits for its block.
//  a four-beat queue separates input and back end; the output register holds under stall.
//  reset clears position, counter and key registers; no clearing pass.
// ----------------------------------------------------------------------------
module salsa20_stream_cipher #(
    parameter int unsigned ROUND_COUNT = s20sc_pkg::ROUND_COUNT_DEF,
    parameter int unsigned QUEUE_DEPTH = s20sc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_in_byte,
    input  logic                              s_last_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_out_byte,
    output logic                              m_out_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [s20sc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [s20sc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import s20sc_pkg::*;

    logic       push, q_full, pop, head_valid;
    q_entry_t   push_entry, head;
    core_stat_t core_stat;
    matrix_t    core_words;
    logic       core_start;
    ctr_t       core_start_ctr;

    s20sc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_last_byte (s_last_byte),
        .push        (push),
        .push_entry  (push_entry),
        .q_full      (q_full)
    );

    s20sc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    s20sc_core #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (core_start),
        .start_ctr (core_start_ctr),
        .stat      (core_stat),
        .words     (core_words)
    );

    s20sc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .core_stat      (core_stat),
        .core_words     (core_words),
        .core_start     (core_start),
        .core_start_ctr (core_start_ctr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_out_last     (m_out_last)
    );

endmodule
